>>> src/keyed_value_pair_table_core_defines.svh
// assertion macros for the keyed value pair table checker
`ifndef KEYED_VALUE_PAIR_TABLE_CORE_DEFINES_SVH
`define KEYED_VALUE_PAIR_TABLE_CORE_DEFINES_SVH

// concurrent assertion on the rising clock, disabled while reset is high
`define KVPT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion on the rising clock, checked during reset too
`define KVPT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/kvpt_pkg.sv
// shared types and constants of the keyed value pair table
package kvpt_pkg;

   localparam int KEY_W         = 16;
   localparam int VAL_W         = 32;
   localparam int OP_W          = 2;
   localparam int CSR_W         = 4;
   localparam int DEPTH_DEFAULT = 8;
   localparam logic [CSR_W-1:0] SLOTS_RESET = 4'd8;

   typedef enum logic [OP_W-1:0] {
      OP_GET   = 2'd0,
      OP_PUT   = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] slot_key;
      logic             accept_free;
   } cmp_req_type;

endpackage

>>> src/kvpt_if.sv
// request, response and register write channels
interface kvpt_req_if;
   logic                             valid;
   logic                             ready;
   logic [kvpt_pkg::OP_W-1:0]        opcode;
   logic [kvpt_pkg::KEY_W-1:0]       key;
   logic signed [kvpt_pkg::VAL_W-1:0] value_one;
   logic signed [kvpt_pkg::VAL_W-1:0] value_two;
   modport source (output valid, opcode, key, value_one, value_two, input ready);
   modport sink   (input valid, opcode, key, value_one, value_two, output ready);
endinterface

interface kvpt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             success;
   logic signed [kvpt_pkg::VAL_W-1:0] read_one;
   logic signed [kvpt_pkg::VAL_W-1:0] read_two;
   modport source (output valid, success, read_one, read_two, input ready);
   modport sink   (input valid, success, read_one, read_two, output ready);
endinterface

interface kvpt_csr_if;
   logic                       valid;
   logic                       ready;
   logic [kvpt_pkg::CSR_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> src/kvpt_ram.sv
// generic single write port ram with registered read
module kvpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/kvpt_slot_cmp.sv
// slot qualifier: key match, or free slot when a put may take it
module kvpt_slot_cmp (
   input  kvpt_pkg::cmp_req_type req,
   output logic                  hit
);

   logic key_eq;
   logic slot_free;

   assign key_eq    = (req.slot_key == req.key);
   assign slot_free = (req.slot_key == '0);
   assign hit       = key_eq || (req.accept_free && slot_free);

endmodule

>>> src/keyed_value_pair_table_core.sv
// keyed value pair table: one slot scanned per cycle through a shared compare unit
// with no slot to search (zero slots in use or an unknown opcode) a request goes straight to ST_FIN;
// else slots from index 0 are compared until the first qualifying slot or slot min(slots_in_use, depth) - 1;
// a new request is taken in ST_IDLE only after the previous response is loaded, which may still be waiting
// reset clears all slot valid bits at once, so every slot reads free with zero values
// reset sets slots_in_use to 8 and drops any pending response
module keyed_value_pair_table_core #(
   parameter int TABLE_DEPTH = kvpt_pkg::DEPTH_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   kvpt_req_if.sink    req_ch,
   kvpt_rsp_if.source  rsp_ch,
   kvpt_csr_if.sink    csr_ch
);

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int LIM_W  = (CNT_W > kvpt_pkg::CSR_W) ? CNT_W : kvpt_pkg::CSR_W;
   localparam int SLOT_W = kvpt_pkg::KEY_W + 2 * kvpt_pkg::VAL_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type                           state_ff, state_in;
   logic [kvpt_pkg::CSR_W-1:0]          slots_ff, slots_in;
   logic [kvpt_pkg::OP_W-1:0]           op_ff, op_in;
   logic [kvpt_pkg::KEY_W-1:0]          key_ff, key_in;
   logic signed [kvpt_pkg::VAL_W-1:0]   v1_ff, v1_in;
   logic signed [kvpt_pkg::VAL_W-1:0]   v2_ff, v2_in;
   logic [CNT_W-1:0]                    limit_ff, limit_in;
   logic [CNT_W-1:0]                    rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]                    cmp_idx_ff, cmp_idx_in;
   logic                                cmp_vld_ff, cmp_vld_in;
   logic                                slot_vld_ff, slot_vld_in;
   logic [TABLE_DEPTH-1:0]              valid_ff, valid_in;
   logic                                res_ok_ff, res_ok_in;
   logic signed [kvpt_pkg::VAL_W-1:0]   res_one_ff, res_one_in;
   logic signed [kvpt_pkg::VAL_W-1:0]   res_two_ff, res_two_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_ok_ff, rsp_ok_in;
   logic signed [kvpt_pkg::VAL_W-1:0]   rsp_one_ff, rsp_one_in;
   logic signed [kvpt_pkg::VAL_W-1:0]   rsp_two_ff, rsp_two_in;

   logic                                accept;
   logic                                op_known;
   logic [LIM_W-1:0]                    csr_ext;
   logic [LIM_W-1:0]                    depth_ext;
   logic [CNT_W-1:0]                    lim_now;
   logic                                rd_go;
   logic                                last;
   logic                                hit;
   logic                                ram_we;
   logic [SLOT_W-1:0]                   ram_wdata;
   logic [SLOT_W-1:0]                   ram_rdata;
   logic [kvpt_pkg::KEY_W-1:0]          slot_key;
   logic signed [kvpt_pkg::VAL_W-1:0]   slot_one;
   logic signed [kvpt_pkg::VAL_W-1:0]   slot_two;
   kvpt_pkg::cmp_req_type               cmp_req;

   kvpt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (cmp_idx_ff[IDX_W-1:0]),
      .wdata (ram_wdata),
      .raddr (rd_idx_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   // never written slots read as free with zero values
   assign slot_key = slot_vld_ff ? ram_rdata[SLOT_W-1 -: kvpt_pkg::KEY_W] : '0;
   assign slot_one = slot_vld_ff ? ram_rdata[2*kvpt_pkg::VAL_W-1 -: kvpt_pkg::VAL_W] : '0;
   assign slot_two = slot_vld_ff ? ram_rdata[kvpt_pkg::VAL_W-1:0] : '0;

   assign cmp_req.key         = key_ff;
   assign cmp_req.slot_key    = slot_key;
   assign cmp_req.accept_free = (op_ff == kvpt_pkg::OP_PUT);

   kvpt_slot_cmp u_slot_cmp (
      .req (cmp_req),
      .hit (hit)
   );

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.success = rsp_ok_ff;
   assign rsp_ch.read_one = rsp_one_ff;
   assign rsp_ch.read_two = rsp_two_ff;

   assign accept    = req_ch.valid && req_ch.ready;
   assign op_known  = (req_ch.opcode == kvpt_pkg::OP_GET) ||
                      (req_ch.opcode == kvpt_pkg::OP_PUT) ||
                      (req_ch.opcode == kvpt_pkg::OP_CLEAR);
   assign csr_ext   = LIM_W'(slots_ff);
   assign depth_ext = LIM_W'(TABLE_DEPTH);
   assign lim_now   = (csr_ext > depth_ext) ? CNT_W'(depth_ext) : CNT_W'(csr_ext);
   assign rd_go     = (state_ff == ST_SCAN) && (rd_idx_ff < limit_ff);
   assign last      = (cmp_idx_ff == limit_ff - CNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      slots_in     = slots_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      limit_in     = limit_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      slot_vld_in  = valid_ff[rd_idx_ff[IDX_W-1:0]];
      valid_in     = valid_ff;
      res_ok_in    = res_ok_ff;
      res_one_in   = res_one_ff;
      res_two_in   = res_two_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_one_in   = rsp_one_ff;
      rsp_two_in   = rsp_two_ff;
      ram_we       = 1'b0;
      ram_wdata    = '0;

      if (csr_ch.valid && csr_ch.ready) begin
         slots_in = csr_ch.data;
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_ch.opcode;
               key_in    = req_ch.key;
               v1_in     = req_ch.value_one;
               v2_in     = req_ch.value_two;
               limit_in  = lim_now;
               rd_idx_in = '0;
               if ((lim_now == '0) || !op_known) begin
                  res_ok_in  = (req_ch.opcode == kvpt_pkg::OP_CLEAR);
                  res_one_in = '0;
                  res_two_in = '0;
                  state_in   = ST_FIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_go) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            cmp_vld_in = rd_go;
            if (cmp_vld_ff) begin
               if (hit) begin
                  res_ok_in  = 1'b1;
                  res_one_in = (op_ff == kvpt_pkg::OP_GET) ? slot_one : '0;
                  res_two_in = (op_ff == kvpt_pkg::OP_GET) ? slot_two : '0;
                  if (op_ff == kvpt_pkg::OP_PUT) begin
                     ram_we    = 1'b1;
                     ram_wdata = {key_ff, v1_ff, v2_ff};
                  end else if (op_ff == kvpt_pkg::OP_CLEAR) begin
                     ram_we    = 1'b1;
                     ram_wdata = {slot_key, {(2 * kvpt_pkg::VAL_W){1'b0}}};
                  end
                  cmp_vld_in = 1'b0;
                  state_in   = ST_FIN;
               end else if (last) begin
                  res_ok_in  = (op_ff == kvpt_pkg::OP_CLEAR);
                  res_one_in = '0;
                  res_two_in = '0;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_one_in   = res_one_ff;
               rsp_two_in   = res_two_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ram_we) begin
         valid_in[cmp_idx_ff[IDX_W-1:0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slots_ff     <= kvpt_pkg::SLOTS_RESET;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slots_ff     <= slots_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
      limit_ff    <= limit_in;
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      slot_vld_ff <= slot_vld_in;
      res_ok_ff   <= res_ok_in;
      res_one_ff  <= res_one_in;
      res_two_ff  <= res_two_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_one_ff  <= rsp_one_in;
      rsp_two_ff  <= rsp_two_in;
   end

endmodule

>>> src/kvpt_checker.sv
// port level checks of the keyed value pair table and their bind
`include "keyed_value_pair_table_core_defines.svh"

module kvpt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_success,
   input logic signed [kvpt_pkg::VAL_W-1:0] rsp_read_one,
   input logic signed [kvpt_pkg::VAL_W-1:0] rsp_read_two
);

   // a stalled response stays offered
   `KVPT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   // one request at a time
   `KVPT_ASSERT(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while busy")
   // no response can appear in the cycle right after a request
   `KVPT_ASSERT(a_no_early_rsp, clock, reset, req_valid && req_ready |=> !$rose(rsp_valid), "response too early")
   // nonzero read data only with a successful response
   `KVPT_ASSERT(a_data_needs_hit, clock, reset, rsp_valid && (rsp_read_one != 0 || rsp_read_two != 0) |-> rsp_success, "read data without success")

endmodule

bind keyed_value_pair_table_core kvpt_checker u_kvpt_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_success  (rsp_ch.success),
   .rsp_read_one (rsp_ch.read_one),
   .rsp_read_two (rsp_ch.read_two)
);
